/* src/half_space_point_clip_bounds_defines.svh */
// assertion macros for the half-space clipper checker
`ifndef HALF_SPACE_POINT_CLIP_BOUNDS_DEFINES_SVH
`define HALF_SPACE_POINT_CLIP_BOUNDS_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define HSPCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define HSPCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hspcb_pkg.sv */
// shared constants and types for the half-space point clipper
`timescale 1ns / 1ps

package hspcb_pkg;

  localparam int NUM_PLANES_DEF       = 6;
  localparam int COORD_BITS_DEF       = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 10;

  // register file layout
  localparam int PLANE_REGS  = 6;
  localparam int PLANE_W     = 64;
  localparam int NORMAL_W    = 12;
  localparam int DIST_W      = 28;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PIU_W       = 3;
  localparam int MODE_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PLANES_IN_USE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE     = 3'd7;

  localparam logic [MODE_W-1:0] CLIP_MODE_RESET = 2'd2;
  localparam int MODE_ENABLE_BIT = 0;
  localparam int MODE_INSIDE_BIT = 1;

  // front-to-back request queue
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* src/half_space_point_clip_bounds.sv */
// an accepted request passes stage a, stage b, the queue and the result register before its result shows
// throughput: one request per cycle, unless a full queue or a stalled result holds the front end
// a four-entry queue decouples classification from the box tracker and result register
// reset (async, active low) clears valids, queue, box state and registers;
// planes_in_use resets to 0 and clip_mode to 2
`timescale 1ns / 1ps

module half_space_point_clip_bounds #(
  parameter int NUM_PLANES       = hspcb_pkg::NUM_PLANES_DEF,
  parameter int COORD_BITS       = hspcb_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = hspcb_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hspcb_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [hspcb_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [hspcb_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_BITS-1:0]         point_x_i,
  input  logic signed [COORD_BITS-1:0]         point_y_i,
  input  logic signed [COORD_BITS-1:0]         point_z_i,
  input  logic                                 new_cloud_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 kept_o,
  output logic signed [COORD_BITS-1:0]         out_x_o,
  output logic signed [COORD_BITS-1:0]         out_y_o,
  output logic signed [COORD_BITS-1:0]         out_z_o,
  output logic                                 any_kept_o,
  output logic signed [COORD_BITS-1:0]         min_x_o,
  output logic signed [COORD_BITS-1:0]         min_y_o,
  output logic signed [COORD_BITS-1:0]         min_z_o,
  output logic signed [COORD_BITS-1:0]         max_x_o,
  output logic signed [COORD_BITS-1:0]         max_y_o,
  output logic signed [COORD_BITS-1:0]         max_z_o
);

  localparam int ITEM_W = 3 * COORD_BITS + 2;

  logic [hspcb_pkg::PLANE_W-1:0] plane_q [hspcb_pkg::PLANE_REGS];
  logic [hspcb_pkg::PIU_W-1:0]   piu_q;
  logic [hspcb_pkg::MODE_W-1:0]  mode_q;
  logic [hspcb_pkg::CFG_IDX_W-1:0] idx;
  logic                          wr_en;

  hspcb_pkg::queue_stat_t q_stat;
  logic                   push, pop;
  logic [ITEM_W-1:0]      push_data, pop_data;

  assign pready = 1'b1;
  assign idx    = paddr[hspcb_pkg::CFG_ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hspcb_pkg::PLANE_REGS; i++) plane_q[i] <= '0;
      piu_q  <= '0;
      mode_q <= hspcb_pkg::CLIP_MODE_RESET;
    end else if (wr_en) begin
      case (idx)
        hspcb_pkg::REG_PLANES_IN_USE: piu_q  <= pwdata[hspcb_pkg::PIU_W-1:0];
        hspcb_pkg::REG_CLIP_MODE:     mode_q <= pwdata[hspcb_pkg::MODE_W-1:0];
        default:                      plane_q[idx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hspcb_pkg::REG_PLANES_IN_USE: prdata = hspcb_pkg::CFG_DATA_W'(piu_q);
      hspcb_pkg::REG_CLIP_MODE:     prdata = hspcb_pkg::CFG_DATA_W'(mode_q);
      default:                      prdata = plane_q[idx];
    endcase
  end

  hspcb_front #(
    .NUM_PLANES       (NUM_PLANES),
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
    .ITEM_W           (ITEM_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .new_cloud_i     (new_cloud_i),
    .planes_i        (plane_q),
    .planes_in_use_i (piu_q),
    .clip_mode_i     (mode_q),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  hspcb_queue #(
    .ITEM_W (ITEM_W),
    .DEPTH  (hspcb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  hspcb_back #(
    .COORD_BITS (COORD_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kept_o      (kept_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .any_kept_o  (any_kept_o),
    .min_x_o     (min_x_o),
    .min_y_o     (min_y_o),
    .min_z_o     (min_z_o),
    .max_x_o     (max_x_o),
    .max_y_o     (max_y_o),
    .max_z_o     (max_z_o)
  );

endmodule

/* src/hspcb_front.sv */
// front end: multiplies the point against each plane, then classifies it
`timescale 1ns / 1ps

module hspcb_front #(
  parameter int NUM_PLANES       = hspcb_pkg::NUM_PLANES_DEF,
  parameter int COORD_BITS       = hspcb_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = hspcb_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int ITEM_W           = 3 * COORD_BITS + 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          point_x_i,
  input  logic signed [COORD_BITS-1:0]          point_y_i,
  input  logic signed [COORD_BITS-1:0]          point_z_i,
  input  logic                                  new_cloud_i,
  input  logic [hspcb_pkg::PLANE_W-1:0]         planes_i [hspcb_pkg::PLANE_REGS],
  input  logic [hspcb_pkg::PIU_W-1:0]           planes_in_use_i,
  input  logic [hspcb_pkg::MODE_W-1:0]          clip_mode_i,
  input  hspcb_pkg::queue_stat_t                q_stat_i,
  output logic                                  push_o,
  output logic [ITEM_W-1:0]                     push_data_o
);

  localparam int PROD_W  = hspcb_pkg::NORMAL_W + COORD_BITS;
  localparam int DSH_W   = hspcb_pkg::DIST_W + NORMAL_FRAC_BITS;
  localparam int SUM_A   = PROD_W + 2;
  localparam int SUM_W   = ((SUM_A > DSH_W) ? SUM_A : DSH_W) + 1;

  // stage a: point and flag, products live in the lanes
  logic                          a_valid_q;
  logic signed [COORD_BITS-1:0]  ax_q, ay_q, az_q;
  logic                          anc_q;

  // stage b: decision
  logic                          b_valid_q;
  logic [ITEM_W-1:0]             b_item_q;

  logic                          a_ready, b_ready;
  logic                          a_load;
  logic [hspcb_pkg::PIU_W-1:0]   count;
  logic                          clip_act;
  logic [NUM_PLANES-1:0]         pass;
  logic                          in_all, kept;

  assign count = (planes_in_use_i > hspcb_pkg::PIU_W'(NUM_PLANES)) ?
                 hspcb_pkg::PIU_W'(NUM_PLANES) : planes_in_use_i;
  assign clip_act = clip_mode_i[hspcb_pkg::MODE_ENABLE_BIT] && (count != '0);

  assign push_o     = b_valid_q && !q_stat_i.full;
  assign b_ready    = !b_valid_q || !q_stat_i.full;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;
  assign a_load     = in_valid_i && a_ready;
  assign push_data_o = b_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
    logic signed [hspcb_pkg::NORMAL_W-1:0] nx, ny, nz;
    logic signed [DSH_W-1:0]               dsh;
    logic signed [SUM_W-1:0]               sum;
    logic signed [PROD_W-1:0]              px_q, py_q, pz_q;
    logic                                  en_q;

    assign nx  = planes_i[i][11:0];
    assign ny  = planes_i[i][23:12];
    assign nz  = planes_i[i][35:24];
    assign dsh = $signed({planes_i[i][63:36], {NORMAL_FRAC_BITS{1'b0}}});

    always_ff @(posedge clk_i) begin
      if (a_load) begin
        px_q <= PROD_W'(nx) * PROD_W'(point_x_i);
        py_q <= PROD_W'(ny) * PROD_W'(point_y_i);
        pz_q <= PROD_W'(nz) * PROD_W'(point_z_i);
        // zero normals and planes past the count drop out of the test
        en_q <= (hspcb_pkg::PIU_W'(i) < count) &&
                (planes_i[i][35:0] != '0);
      end
    end

    assign sum = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q) + SUM_W'(dsh);
    assign pass[i] = !en_q || !sum[SUM_W-1];
  end

  assign in_all = &pass;
  assign kept   = clip_act ?
                  (clip_mode_i[hspcb_pkg::MODE_INSIDE_BIT] ? in_all : !in_all) : 1'b1;

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      ax_q  <= point_x_i;
      ay_q  <= point_y_i;
      az_q  <= point_z_i;
      anc_q <= new_cloud_i;
    end
    if (b_ready && a_valid_q) begin
      b_item_q <= {anc_q, kept, az_q, ay_q, ax_q};
    end
  end

endmodule

/* src/hspcb_queue.sv */
// short request queue between the classifier and the box tracker
`timescale 1ns / 1ps

module hspcb_queue #(
  parameter int ITEM_W = 74,
  parameter int DEPTH  = hspcb_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [ITEM_W-1:0]      push_data_i,
  input  logic                   pop_i,
  output logic [ITEM_W-1:0]      pop_data_o,
  output hspcb_pkg::queue_stat_t stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ITEM_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign pop_data_o   = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

/* src/hspcb_back.sv */
// back end: running bounding box of kept points and the result register
`timescale 1ns / 1ps

module hspcb_back #(
  parameter int COORD_BITS = hspcb_pkg::COORD_BITS_DEF,
  parameter int ITEM_W     = 3 * COORD_BITS + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hspcb_pkg::queue_stat_t        q_stat_i,
  input  logic [ITEM_W-1:0]             pop_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kept_o,
  output logic signed [COORD_BITS-1:0]  out_x_o,
  output logic signed [COORD_BITS-1:0]  out_y_o,
  output logic signed [COORD_BITS-1:0]  out_z_o,
  output logic                          any_kept_o,
  output logic signed [COORD_BITS-1:0]  min_x_o,
  output logic signed [COORD_BITS-1:0]  min_y_o,
  output logic signed [COORD_BITS-1:0]  min_z_o,
  output logic signed [COORD_BITS-1:0]  max_x_o,
  output logic signed [COORD_BITS-1:0]  max_y_o,
  output logic signed [COORD_BITS-1:0]  max_z_o
);

  logic                         have_q, have_d;
  logic signed [COORD_BITS-1:0] lo_q [3];
  logic signed [COORD_BITS-1:0] hi_q [3];
  logic signed [COORD_BITS-1:0] lo_d [3];
  logic signed [COORD_BITS-1:0] hi_d [3];
  logic signed [COORD_BITS-1:0] pt [3];
  logic                         it_new, it_kept;
  logic                         out_valid_q;
  logic                         res_kept_q;
  logic signed [COORD_BITS-1:0] res_pt_q [3];

  assign pt[0]   = pop_data_i[COORD_BITS-1:0];
  assign pt[1]   = pop_data_i[2*COORD_BITS-1:COORD_BITS];
  assign pt[2]   = pop_data_i[3*COORD_BITS-1:2*COORD_BITS];
  assign it_kept = pop_data_i[3*COORD_BITS];
  assign it_new  = pop_data_i[3*COORD_BITS+1];

  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    have_d = it_new ? 1'b0 : have_q;
    for (int i = 0; i < 3; i++) begin
      lo_d[i] = it_new ? '0 : lo_q[i];
      hi_d[i] = it_new ? '0 : hi_q[i];
    end
    if (it_kept) begin
      for (int i = 0; i < 3; i++) begin
        // first kept point of a cloud seeds both corners
        if (!have_d || pt[i] < lo_d[i]) lo_d[i] = pt[i];
        if (!have_d || pt[i] > hi_d[i]) hi_d[i] = pt[i];
      end
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        have_q      <= have_d;
        for (int i = 0; i < 3; i++) begin
          lo_q[i] <= lo_d[i];
          hi_q[i] <= hi_d[i];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_kept_q <= it_kept;
      for (int i = 0; i < 3; i++) res_pt_q[i] <= pt[i];
    end
  end

  // box state only moves on a pop, so it doubles as the result's box
  assign out_valid_o = out_valid_q;
  assign kept_o      = res_kept_q;
  assign out_x_o     = res_pt_q[0];
  assign out_y_o     = res_pt_q[1];
  assign out_z_o     = res_pt_q[2];
  assign any_kept_o  = have_q;
  assign min_x_o     = lo_q[0];
  assign min_y_o     = lo_q[1];
  assign min_z_o     = lo_q[2];
  assign max_x_o     = hi_q[0];
  assign max_y_o     = hi_q[1];
  assign max_z_o     = hi_q[2];

endmodule

/* src/hspcb_checker.sv */
// port-level checks for the half-space clipper, bound to the top level
`timescale 1ns / 1ps
`include "half_space_point_clip_bounds_defines.svh"

module hspcb_checker #(
  parameter int COORD_BITS = hspcb_pkg::COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         kept_o,
  input logic signed [COORD_BITS-1:0] out_x_o,
  input logic signed [COORD_BITS-1:0] out_y_o,
  input logic signed [COORD_BITS-1:0] out_z_o,
  input logic                         any_kept_o,
  input logic signed [COORD_BITS-1:0] min_x_o,
  input logic signed [COORD_BITS-1:0] min_y_o,
  input logic signed [COORD_BITS-1:0] min_z_o,
  input logic signed [COORD_BITS-1:0] max_x_o,
  input logic signed [COORD_BITS-1:0] max_y_o,
  input logic signed [COORD_BITS-1:0] max_z_o
);

  `HSPCB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_x_o) && $stable(kept_o) && $stable(min_x_o) && $stable(max_z_o), "stalled result changed")
  `HSPCB_ASSERT_NOW(a_empty_box, out_valid_o && !any_kept_o, min_x_o == 0 && min_y_o == 0 && min_z_o == 0 && max_x_o == 0 && max_y_o == 0 && max_z_o == 0, "empty box not zero")
  `HSPCB_ASSERT_NOW(a_kept_any, out_valid_o && kept_o, any_kept_o, "kept point without box")
  `HSPCB_ASSERT_NOW(a_kept_in_box, out_valid_o && kept_o, min_x_o <= out_x_o && out_x_o <= max_x_o && min_y_o <= out_y_o && out_y_o <= max_y_o && min_z_o <= out_z_o && out_z_o <= max_z_o, "kept point outside box")

endmodule

bind half_space_point_clip_bounds hspcb_checker #(.COORD_BITS(COORD_BITS)) u_hspcb_checker (.*);

/* verif/half_space_point_clip_bounds_tb.sv */
// self-checking testbench for the half-space point clipper with running bounding box
`timescale 1ns / 1ps

module half_space_point_clip_bounds_tb;

  typedef logic signed [hspcb_pkg::COORD_BITS_DEF-1:0] coord_t;

  typedef struct packed {
    logic   kept;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   any_kept;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } clip_result_t;

  localparam coord_t COORD_MAX = {1'b0, {(hspcb_pkg::COORD_BITS_DEF-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(hspcb_pkg::COORD_BITS_DEF-1){1'b0}}};
  localparam int D_MAX = (1 << (hspcb_pkg::DIST_W - 1)) - 1;
  localparam int D_MIN = -(1 << (hspcb_pkg::DIST_W - 1));

  // tracks clip config, box state and the results still owed by the block
  class clip_box_predictor;
    logic [hspcb_pkg::PLANE_W-1:0] plane_word [hspcb_pkg::PLANE_REGS];
    logic [hspcb_pkg::PIU_W-1:0]   planes_used;
    logic [hspcb_pkg::MODE_W-1:0]  mode;
    bit                            box_valid;
    coord_t                        low_pt [3];
    coord_t                        high_pt [3];
    clip_result_t                  expected_points [$];
    int                            errors;

    function new();
      foreach (plane_word[i]) plane_word[i] = '0;
      planes_used = '0;
      mode = hspcb_pkg::CLIP_MODE_RESET;
      clear_box();
      errors = 0;
    endfunction

    function void clear_box();
      box_valid = 0;
      foreach (low_pt[i]) begin
        low_pt[i] = '0;
        high_pt[i] = '0;
      end
    endfunction

    function void set_reg(int idx, logic [hspcb_pkg::CFG_DATA_W-1:0] value);
      if (idx < hspcb_pkg::PLANE_REGS) plane_word[idx] = value;
      else if (idx == hspcb_pkg::REG_PLANES_IN_USE)
        planes_used = value[hspcb_pkg::PIU_W-1:0];
      else if (idx == hspcb_pkg::REG_CLIP_MODE) mode = value[hspcb_pkg::MODE_W-1:0];
    endfunction

    function bit passes_planes(coord_t px, coord_t py, coord_t pz, int count);
      logic signed [hspcb_pkg::NORMAL_W-1:0] nx, ny, nz;
      logic signed [hspcb_pkg::DIST_W-1:0]   d_val;
      longint                                acc;
      for (int i = 0; i < count; i++) begin
        nx = plane_word[i][hspcb_pkg::NORMAL_W-1:0];
        ny = plane_word[i][2*hspcb_pkg::NORMAL_W-1:hspcb_pkg::NORMAL_W];
        nz = plane_word[i][3*hspcb_pkg::NORMAL_W-1:2*hspcb_pkg::NORMAL_W];
        d_val = plane_word[i][hspcb_pkg::PLANE_W-1:3*hspcb_pkg::NORMAL_W];
        // zero normal planes never clip
        if (nx == 0 && ny == 0 && nz == 0) continue;
        acc = longint'(nx) * longint'(px) + longint'(ny) * longint'(py)
            + longint'(nz) * longint'(pz)
            + (longint'(d_val) <<< hspcb_pkg::NORMAL_FRAC_BITS_DEF);
        if (acc < 0) return 0;
      end
      return 1;
    endfunction

    function void note_point(coord_t px, coord_t py, coord_t pz, bit fresh);
      coord_t       p [3];
      int           count;
      bit           in_all;
      bit           keep;
      clip_result_t r;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      if (fresh) clear_box();
      count = (planes_used > hspcb_pkg::NUM_PLANES_DEF) ?
              hspcb_pkg::NUM_PLANES_DEF : int'(planes_used);
      if (mode[hspcb_pkg::MODE_ENABLE_BIT] && count > 0) begin
        in_all = passes_planes(px, py, pz, count);
        keep = mode[hspcb_pkg::MODE_INSIDE_BIT] ? in_all : !in_all;
      end else begin
        keep = 1;
      end
      if (keep) begin
        if (!box_valid) begin
          foreach (p[i]) begin
            low_pt[i] = p[i];
            high_pt[i] = p[i];
          end
          box_valid = 1;
        end else begin
          foreach (p[i]) begin
            if (p[i] < low_pt[i]) low_pt[i] = p[i];
            if (p[i] > high_pt[i]) high_pt[i] = p[i];
          end
        end
      end
      r = '{keep, px, py, pz, box_valid, low_pt[0], low_pt[1], low_pt[2],
            high_pt[0], high_pt[1], high_pt[2]};
      expected_points.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_point(clip_result_t got);
      clip_result_t want;
      if (expected_points.size() == 0) begin
        $error("result with no request waiting: x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      compare_field("kept", want.kept, got.kept);
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
      compare_field("any_kept", want.any_kept, got.any_kept);
      compare_field("min_x", want.min_x, got.min_x);
      compare_field("min_y", want.min_y, got.min_y);
      compare_field("min_z", want.min_z, got.min_z);
      compare_field("max_x", want.max_x, got.max_x);
      compare_field("max_y", want.max_y, got.max_y);
      compare_field("max_z", want.max_z, got.max_z);
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [hspcb_pkg::CFG_ADDR_W-1:0] paddr;
  logic [hspcb_pkg::CFG_DATA_W-1:0] pwdata;
  logic [hspcb_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;
  logic                             in_valid_i;
  logic                             in_ready_o;
  coord_t                           point_x_i;
  coord_t                           point_y_i;
  coord_t                           point_z_i;
  logic                             new_cloud_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic                             kept_o;
  coord_t                           out_x_o, out_y_o, out_z_o;
  logic                             any_kept_o;
  coord_t                           min_x_o, min_y_o, min_z_o;
  coord_t                           max_x_o, max_y_o, max_z_o;

  // shared pacing controls, written with nonblocking assignments
  logic calm;
  int   stall_asks;

  clip_box_predictor box_model = new();
  logic [hspcb_pkg::PLANE_W-1:0] plane_set [hspcb_pkg::PLANE_REGS];

  half_space_point_clip_bounds DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .new_cloud_i (new_cloud_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kept_o      (kept_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .any_kept_o  (any_kept_o),
    .min_x_o     (min_x_o),
    .min_y_o     (min_y_o),
    .min_z_o     (min_z_o),
    .max_x_o     (max_x_o),
    .max_y_o     (max_y_o),
    .max_z_o     (max_z_o)
  );

  always #5 clk_i = ~clk_i;

  // a request is noted before the result check so a result in the same cycle as its request would still line up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        box_model.note_point(point_x_i, point_y_i, point_z_i, new_cloud_i);
      if (out_valid_o && out_ready_i)
        box_model.check_point('{kept_o, out_x_o, out_y_o, out_z_o, any_kept_o,
                                min_x_o, min_y_o, min_z_o, max_x_o, max_y_o, max_z_o});
    end
  end

  // result side: random back-pressure plus long hold-offs on request
  initial begin
    int hold;
    int stall_seen;
    hold = 0;
    stall_seen = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_asks != stall_seen) begin
        stall_seen = stall_asks;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  function automatic logic [hspcb_pkg::PLANE_W-1:0] pack_plane(int nx, int ny, int nz,
                                                               int d);
    return {hspcb_pkg::DIST_W'(d), hspcb_pkg::NORMAL_W'(nz), hspcb_pkg::NORMAL_W'(ny),
            hspcb_pkg::NORMAL_W'(nx)};
  endfunction

  function automatic logic [hspcb_pkg::PLANE_W-1:0] rand_plane();
    int nx, ny, nz, d;
    nx = int'($urandom_range(0, 4095)) - 2048;
    ny = int'($urandom_range(0, 4095)) - 2048;
    nz = int'($urandom_range(0, 4095)) - 2048;
    if ($urandom_range(0, 7) == 0) begin
      nx = 0;
      ny = 0;
      nz = 0;
    end
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, (1 << hspcb_pkg::DIST_W) - 1);
      1: d = 0;
      default: d = int'($urandom_range(0, 32767)) - 16384;
    endcase
    return pack_plane(nx, ny, nz, d);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3, 4: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // all driving tasks start and end at a rising edge
  task automatic push_point(coord_t x, coord_t y, coord_t z, bit fresh);
    if (!calm) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    point_x_i   <= x;
    point_y_i   <= y;
    point_z_i   <= z;
    new_cloud_i <= fresh;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (box_model.expected_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hspcb_pkg::CFG_IDX_W-1:0] idx,
                           logic [hspcb_pkg::CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    box_model.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic load_planes();
    for (int i = 0; i < hspcb_pkg::PLANE_REGS; i++)
      write_reg(hspcb_pkg::CFG_IDX_W'(i), plane_set[i]);
  endtask

  task automatic random_phase(int count, bit squeeze);
    drain_results();
    foreach (plane_set[i]) plane_set[i] = rand_plane();
    load_planes();
    write_reg(hspcb_pkg::REG_PLANES_IN_USE, hspcb_pkg::CFG_DATA_W'($urandom_range(0, 7)));
    // clipping on most of the time
    write_reg(hspcb_pkg::REG_CLIP_MODE,
              hspcb_pkg::CFG_DATA_W'($urandom_range(0, 3) | ($urandom_range(0, 3) != 0)));
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == 8) stall_asks <= stall_asks + 1;
      if (squeeze && i == 35) drain_results();
      push_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    point_x_i   <= '0;
    point_y_i   <= '0;
    point_z_i   <= '0;
    new_cloud_i <= 1'b0;
    calm        <= 1'b0;
    stall_asks  <= 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: clipping off, every point kept, box spans the extremes
    push_point(COORD_MIN, COORD_MAX, 0, 1'b1);
    push_point(COORD_MAX, COORD_MIN, -1, 1'b0);
    push_point(0, 0, COORD_MAX, 1'b0);
    push_point(-1, 1, COORD_MIN, 1'b0);

    // x >= 0, a zero-normal plane, extreme normals, all-ones planes
    drain_results();
    plane_set[0] = pack_plane(1 << hspcb_pkg::NORMAL_FRAC_BITS_DEF, 0, 0, 0);
    plane_set[1] = pack_plane(0, 0, 0, -5);
    plane_set[2] = pack_plane(-2048, 2047, -2048, D_MAX);
    plane_set[3] = '1;
    plane_set[4] = '1;
    plane_set[5] = '1;
    load_planes();
    write_reg(hspcb_pkg::REG_PLANES_IN_USE, 2);
    write_reg(hspcb_pkg::REG_CLIP_MODE, 3);
    push_point(-5, 0, 0, 1'b1);
    push_point(0, 7, 7, 1'b0);
    push_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);

    // keep outside
    drain_results();
    write_reg(hspcb_pkg::REG_CLIP_MODE, 1);
    push_point(-5, 0, 0, 1'b1);
    push_point(0, 7, 7, 1'b0);
    push_point(COORD_MIN, 0, 0, 1'b0);

    // junk upper bits: planes_in_use reads as 7, clamped to all six planes
    drain_results();
    write_reg(hspcb_pkg::REG_PLANES_IN_USE, '1);
    write_reg(hspcb_pkg::REG_CLIP_MODE, 3);
    push_point(-100, -100, -100, 1'b1);
    push_point(0, -2000, 0, 1'b0);
    push_point(5, -1000, 0, 1'b0);
    push_point(0, COORD_MIN, COORD_MIN, 1'b0);

    // clipping on with no planes keeps everything
    drain_results();
    write_reg(hspcb_pkg::REG_PLANES_IN_USE, 0);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);

    drain_results();
    write_reg(hspcb_pkg::REG_PLANES_IN_USE, 6);
    write_reg(hspcb_pkg::REG_CLIP_MODE, 0);
    push_point(-100, 3, 3, 1'b1);

    // most negative distance rejects every point, box stays empty
    drain_results();
    write_reg(hspcb_pkg::CFG_IDX_W'(1), pack_plane(0, 0, 1, D_MIN));
    write_reg(hspcb_pkg::REG_PLANES_IN_USE, 2);
    write_reg(hspcb_pkg::REG_CLIP_MODE, 3);
    push_point(1, 2, 3, 1'b1);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);

    drain_results();
    write_reg(hspcb_pkg::REG_CLIP_MODE, 2);
    push_point(3, 2, 1, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      calm <= (phase == 4);
      random_phase(54, phase == 2);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (box_model.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
